@@ design/assert_macros.svh @@
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ design/ookpw_pkg.sv @@
`default_nettype none

package ookpw_pkg;

	localparam int unsigned MAX_BITS = 32;
	localparam int unsigned PREAMBLE_PULSES = 10;

	// configuration register indexes
	localparam logic [1:0] CFG_TE     = 2'd0;
	localparam logic [1:0] CFG_BITS   = 2'd1;
	localparam logic [1:0] CFG_REPEAT = 2'd2;
	localparam logic [1:0] CFG_GAP    = 2'd3;

	// segment length kinds: 1 te, 3 te, 31 te
	localparam logic [1:0] SEG_SHORT = 2'd0;
	localparam logic [1:0] SEG_LONG  = 2'd1;
	localparam logic [1:0] SEG_SYNC  = 2'd2;

	localparam logic [0:0] OP_TICK  = 1'b0;
	localparam logic [0:0] OP_START = 1'b1;

	typedef struct packed {
		logic [0:0]  opcode;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} out_item_t;

	function automatic logic [20:0] seg_len(input logic [15:0] te, input logic [1:0] kind);
		logic [20:0] n;
		case (kind)
			SEG_SHORT: n = {5'd0, te};
			SEG_LONG:  n = {5'd0, te} + {4'd0, te, 1'b0};
			SEG_SYNC:  n = {te, 5'd0} - {5'd0, te};
			default:   n = {5'd0, te};
		endcase
		return (n == 21'd0) ? 21'd1 : n;
	endfunction

	// payload bit for a data pulse, pulse index counts bits still to send
	function automatic logic cur_bit(input logic [31:0] pl, input logic [5:0] pi);
		logic [5:0] idx;
		idx = pi - 6'd1;
		if (pi == 6'd0 || idx[5]) begin
			return 1'b0;
		end
		return pl[idx[4:0]];
	endfunction

endpackage

`default_nettype wire

@@ design/ook_pulse_width_frame_tx.sv @@
// On-off-keyed pulse-width frame transmitter.
// Input channel (in_valid / in_stall / in_data): each transaction is either a
// one-microsecond tick or a start carrying the payload word. Every input
// transaction yields exactly one output transaction (out_valid / out_stall /
// out_data) with the line level of that microsecond, the busy flag and a
// done flag on the item where the last frame ends or a zero-repeat start.
// The input register feeds the frame sequencer, whose result is captured in
// the result register. Throughput is one transaction per clock while the
// receiver does not stall; the sequencer (phase, pulse and tick counters)
// settles one item per cycle.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_stall is raised; nothing is dropped.
// Configuration (te, bit count, repeat count, gap) goes through cfg_we /
// cfg_index / cfg_data; the user must write it only while no transaction is
// in flight, which the block does not enforce. Reset (arst_n low) returns
// the block to idle with the default configuration and empties both registers.
`default_nettype none

`include "assert_macros.svh"

module ook_pulse_width_frame_tx (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  ookpw_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output ookpw_pkg::out_item_t out_data,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [19:0]           cfg_data
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_PRE  = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_SYNC = 3'd3;
	localparam logic [2:0] PH_GAP  = 3'd4;

	localparam logic [5:0] MAX_BITS_C = 6'(ookpw_pkg::MAX_BITS);
	localparam logic [5:0] PRE_LAST   = 6'(ookpw_pkg::PREAMBLE_PULSES);

	logic [15:0] te_q;
	logic [5:0]  bits_q;
	logic [7:0]  repeat_q;
	logic [19:0] gap_q;

	logic [31:0] payload_q;
	logic [2:0]  phase_q;
	logic [7:0]  repeats_q;
	logic [5:0]  pulse_q;
	logic        high_q;
	logic [20:0] ticks_q;

	logic                 valid_s1;
	ookpw_pkg::in_item_t  item_s1;
	logic                 res_valid_s2;
	ookpw_pkg::out_item_t res_s2;

	logic adv;

	logic [31:0] pl_n;
	logic [2:0]  ph_n;
	logic [7:0]  rep_n;
	logic [5:0]  pi_n;
	logic        hh_n;
	logic [20:0] tl_n;
	logic        done_n;
	logic        level_n;
	logic        busy_c;
	logic [5:0]  nb;

	assign adv       = !res_valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			te_q     <= 16'd350;
			bits_q   <= 6'd24;
			repeat_q <= 8'd4;
			gap_q    <= 20'd10000;
		end else if (cfg_we) begin
			case (cfg_index)
				ookpw_pkg::CFG_TE:     te_q     <= cfg_data[15:0];
				ookpw_pkg::CFG_BITS:   bits_q   <= cfg_data[5:0];
				ookpw_pkg::CFG_REPEAT: repeat_q <= cfg_data[7:0];
				ookpw_pkg::CFG_GAP:    gap_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pl_n    = payload_q;
		ph_n    = phase_q;
		rep_n   = repeats_q;
		pi_n    = pulse_q;
		hh_n    = high_q;
		tl_n    = ticks_q;
		done_n  = 1'b0;
		busy_c  = (phase_q != PH_IDLE);
		level_n = busy_c && (phase_q != PH_GAP) && high_q;
		nb      = (bits_q > MAX_BITS_C) ? MAX_BITS_C : bits_q;

		if (item_s1.opcode == ookpw_pkg::OP_START) begin
			if (!busy_c) begin
				pl_n  = item_s1.payload;
				rep_n = repeat_q;
				if (repeat_q == 8'd0) begin
					done_n = 1'b1;
				end else begin
					ph_n = PH_PRE;
					pi_n = 6'd0;
					hh_n = 1'b1;
					tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_SHORT);
				end
			end
		end else if (busy_c) begin
			if (ticks_q != 21'd0) begin
				tl_n = ticks_q - 21'd1;
			end
			if (tl_n == 21'd0) begin
				// segment finished
				if (phase_q == PH_GAP || (phase_q == PH_SYNC && !high_q && gap_q == 20'd0)) begin
					rep_n = repeats_q - 8'd1;
					if (rep_n == 8'd0) begin
						ph_n   = PH_IDLE;
						hh_n   = 1'b0;
						tl_n   = 21'd0;
						pi_n   = 6'd0;
						done_n = 1'b1;
					end else begin
						ph_n = PH_PRE;
						pi_n = 6'd0;
						hh_n = 1'b1;
						tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_SHORT);
					end
				end else if (high_q) begin
					hh_n = 1'b0;
					if (phase_q == PH_SYNC) begin
						tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_SYNC);
					end else if (phase_q == PH_DATA && ookpw_pkg::cur_bit(payload_q, pulse_q)) begin
						tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_SHORT);
					end else begin
						tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_LONG);
					end
				end else if (phase_q == PH_SYNC) begin
					// sync low done with a nonzero gap
					ph_n = PH_GAP;
					hh_n = 1'b0;
					tl_n = {1'b0, gap_q};
				end else begin
					hh_n = 1'b1;
					if (phase_q == PH_PRE) begin
						pi_n = pulse_q + 6'd1;
						if (pi_n == PRE_LAST) begin
							if (nb != 6'd0) begin
								ph_n = PH_DATA;
								pi_n = nb;
							end else begin
								ph_n = PH_SYNC;
								pi_n = 6'd0;
							end
						end
					end else begin
						pi_n = pulse_q - 6'd1;
						if (pi_n == 6'd0) begin
							ph_n = PH_SYNC;
						end
					end
					if (ph_n == PH_DATA && ookpw_pkg::cur_bit(payload_q, pi_n)) begin
						tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_LONG);
					end else begin
						tl_n = ookpw_pkg::seg_len(te_q, ookpw_pkg::SEG_SHORT);
					end
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= 32'd0;
			phase_q   <= PH_IDLE;
			repeats_q <= 8'd0;
			pulse_q   <= 6'd0;
			high_q    <= 1'b0;
			ticks_q   <= 21'd0;
		end else if (valid_s1 && adv) begin
			payload_q <= pl_n;
			phase_q   <= ph_n;
			repeats_q <= rep_n;
			pulse_q   <= pi_n;
			high_q    <= hh_n;
			ticks_q   <= tl_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2.line_level <= level_n;
			res_s2.busy_res   <= (ph_n != PH_IDLE);
			res_s2.frame_done <= done_n;
		end
	end

	`ASSERT_CLK(a_idle_clear, clk, arst_n, (phase_q == PH_IDLE) |-> (ticks_q == 21'd0 && !high_q), "idle with live segment")
	`ASSERT_CLK(a_done_not_busy, clk, arst_n, (res_valid_s2 && res_s2.frame_done) |-> !res_s2.busy_res, "done while still busy")
	`ASSERT_NEVER(a_pulse_range, clk, arst_n, pulse_q > MAX_BITS_C, "pulse index beyond bit limit")
	`ASSERT_CLK(a_pre_range, clk, arst_n, (phase_q == PH_PRE) |-> (pulse_q < PRE_LAST), "preamble count overrun")
	`ASSERT_CLK(a_stall_holds, clk, arst_n, (valid_s1 && !adv) |=> valid_s1, "input register lost a transaction")

endmodule

`default_nettype wire

@@ dv/tb_ook_pulse_width_frame_tx.sv @@
`timescale 1ns / 100ps

module tb_ook_pulse_width_frame_tx;

	localparam int RAND_ITEMS = 1400;
	localparam int DRAIN_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [3:0] ALL_REGS = 4'hF;
	localparam logic [3:0] TE_GAP_MASK =
		(4'b1 << ookpw_pkg::CFG_TE) | (4'b1 << ookpw_pkg::CFG_GAP);

	class frame_tx_scoreboard;
		localparam int unsigned LONG_TE = 3;
		localparam int unsigned SYNC_TE = 31;

		typedef enum logic [2:0] {ST_IDLE, ST_PRE, ST_DATA, ST_SYNC, ST_GAP} tx_state_t;

		logic [15:0] te;
		logic [5:0]  nbits;
		logic [7:0]  reps_cfg;
		logic [19:0] gap_len;
		logic [31:0] word;
		tx_state_t   st;
		logic [7:0]  reps_left;
		logic [5:0]  pidx;
		logic        high_half;
		logic [20:0] ticks;
		ookpw_pkg::out_item_t levels_due[$];
		int          errors;

		function new();
			te = 16'd350;
			nbits = 6'd24;
			reps_cfg = 8'd4;
			gap_len = 20'd10000;
			word = '0;
			st = ST_IDLE;
			reps_left = '0;
			pidx = '0;
			high_half = 1'b0;
			ticks = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [19:0] val);
			case (idx)
				ookpw_pkg::CFG_TE:     te = val[15:0];
				ookpw_pkg::CFG_BITS:   nbits = val[5:0];
				ookpw_pkg::CFG_REPEAT: reps_cfg = val[7:0];
				ookpw_pkg::CFG_GAP:    gap_len = val;
				default:    ;
			endcase
		endfunction

		function bit busy();
			return st != ST_IDLE;
		endfunction

		function int pending();
			return levels_due.size();
		endfunction

		function logic [20:0] seg_ticks(int unsigned mult);
			int unsigned n;
			n = te * mult;
			return (n == 0) ? 21'd1 : n[20:0];
		endfunction

		function logic data_bit();
			if (pidx == 0 || pidx > 32) return 1'b0;
			return word[pidx - 1];
		endfunction

		function void start_high();
			high_half = 1'b1;
			ticks = (st == ST_DATA && data_bit()) ? seg_ticks(LONG_TE) : seg_ticks(1);
		endfunction

		function void start_low();
			high_half = 1'b0;
			if (st == ST_SYNC) ticks = seg_ticks(SYNC_TE);
			else if (st == ST_DATA && data_bit()) ticks = seg_ticks(1);
			else ticks = seg_ticks(LONG_TE);
		endfunction

		function void start_frame();
			st = ST_PRE;
			pidx = '0;
			start_high();
		endfunction

		function bit close_frame();
			reps_left = reps_left - 8'd1;
			if (reps_left == 0) begin
				st = ST_IDLE;
				high_half = 1'b0;
				ticks = '0;
				pidx = '0;
				return 1'b1;
			end
			start_frame();
			return 1'b0;
		endfunction

		function bit segment_over();
			logic [5:0] nb;
			if (st == ST_GAP) return close_frame();
			if (high_half) begin
				start_low();
				return 1'b0;
			end
			case (st)
				ST_PRE: begin
					pidx = pidx + 6'd1;
					if (pidx < ookpw_pkg::PREAMBLE_PULSES) begin
						start_high();
						return 1'b0;
					end
					nb = (nbits > ookpw_pkg::MAX_BITS) ? 6'(ookpw_pkg::MAX_BITS) : nbits;
					if (nb != 0) begin
						st = ST_DATA;
						pidx = nb;
					end else begin
						st = ST_SYNC;
						pidx = '0;
					end
					start_high();
					return 1'b0;
				end
				ST_DATA: begin
					pidx = pidx - 6'd1;
					if (pidx == 0) st = ST_SYNC;
					start_high();
					return 1'b0;
				end
				default: begin
					// end of sync low half
					if (gap_len != 0) begin
						st = ST_GAP;
						high_half = 1'b0;
						ticks = {1'b0, gap_len};
						return 1'b0;
					end
					return close_frame();
				end
			endcase
			return 1'b0;
		endfunction

		function ookpw_pkg::out_item_t predict_item(ookpw_pkg::in_item_t it);
			ookpw_pkg::out_item_t r;
			logic was_busy;
			was_busy = (st != ST_IDLE);
			r.line_level = was_busy && st != ST_GAP && high_half;
			r.frame_done = 1'b0;
			if (it.opcode == ookpw_pkg::OP_START) begin
				if (!was_busy) begin
					word = it.payload;
					reps_left = reps_cfg;
					if (reps_left == 0) r.frame_done = 1'b1;
					else start_frame();
				end
			end else if (was_busy) begin
				if (ticks != 0) ticks = ticks - 21'd1;
				if (ticks == 0) r.frame_done = segment_over();
			end
			r.busy_res = (st != ST_IDLE);
			return r;
		endfunction

		function void note_item(ookpw_pkg::in_item_t it);
			levels_due.push_back(predict_item(it));
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_level(ookpw_pkg::out_item_t got);
			ookpw_pkg::out_item_t want;
			if (levels_due.size() == 0) begin
				report($sformatf("result %b with nothing expected", got));
				return;
			end
			want = levels_due.pop_front();
			if (got.line_level !== want.line_level)
				report($sformatf("line_level %b, want %b", got.line_level, want.line_level));
			if (got.busy_res !== want.busy_res)
				report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
			if (got.frame_done !== want.frame_done)
				report($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	ookpw_pkg::in_item_t  in_data;
	logic        out_valid;
	logic        out_stall;
	ookpw_pkg::out_item_t out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;

	frame_tx_scoreboard sb;
	logic [19:0] cfg_val [4];
	bit calm;
	bit extremes_done;
	int counted;
	int quiet_cycles = 0;

	ook_pulse_width_frame_tx u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [19:0] pick_te();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3) return 20'd0;
		if (r < 11) return 20'd1;
		if (r < 17) return 20'd2;
		return 20'($urandom_range(3, 5));
	endfunction

	function automatic logic [19:0] pick_bits();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2) return 20'd0;
		if (r < 13) return 20'($urandom_range(1, 8));
		if (r < 17) return 20'($urandom_range(9, 32));
		return 20'($urandom_range(33, 63));
	endfunction

	function automatic logic [19:0] pick_repeat();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 20'd0;
		if (r < 7) return 20'd1;
		return 20'($urandom_range(2, 3));
	endfunction

	function automatic logic [19:0] pick_gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 20'd0;
		if (r < 9) return 20'($urandom_range(1, 20));
		return 20'($urandom_range(21, 300));
	endfunction

	function automatic logic [31:0] pick_word();
		int k;
		k = $urandom_range(0, 31);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 32'd1 << k;
			3:       return ~(32'd1 << k);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [0:0] op, input logic [31:0] word);
		ookpw_pkg::in_item_t it;
		int g;
		it.opcode = op;
		it.payload = word;
		if ((op == ookpw_pkg::OP_TICK && sb.busy()) ||
			(op == ookpw_pkg::OP_START && !sb.busy())) counted++;
		g = pick_gap();
		repeat (g) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// writes only once every transaction in flight has come out
	task automatic apply_cfg(input logic [3:0] mask);
		int i;
		if (mask != 0) begin
			in_valid <= 1'b0;
			while (sb.pending() != 0) @(negedge clk);
			repeat (DRAIN_CYCLES) @(negedge clk);
			for (i = 0; i < 4; i++) begin
				if (mask[i]) begin
					cfg_we <= 1'b1;
					cfg_index <= 2'(i);
					cfg_data <= cfg_val[i];
					sb.set_reg(2'(i), cfg_val[i]);
					@(negedge clk);
				end
			end
			cfg_we <= 1'b0;
		end
	endtask

	// extreme te and gap held only while no segment can end
	task automatic hold_extremes();
		logic [15:0] te_keep;
		logic [19:0] gap_keep;
		te_keep = sb.te;
		gap_keep = sb.gap_len;
		cfg_val[ookpw_pkg::CFG_TE] = 20'hFFFF;
		cfg_val[ookpw_pkg::CFG_GAP] = 20'hFFFFF;
		apply_cfg(TE_GAP_MASK);
		repeat ($urandom_range(1, 3)) send_item(ookpw_pkg::OP_TICK, $urandom);
		cfg_val[ookpw_pkg::CFG_TE] = {4'd0, te_keep};
		cfg_val[ookpw_pkg::CFG_GAP] = gap_keep;
		apply_cfg(TE_GAP_MASK);
	endtask

	task automatic retune();
		cfg_val[ookpw_pkg::CFG_TE] = pick_te();
		cfg_val[ookpw_pkg::CFG_BITS] = pick_bits();
		cfg_val[ookpw_pkg::CFG_REPEAT] = pick_repeat();
		cfg_val[ookpw_pkg::CFG_GAP] = pick_gap_len();
		apply_cfg(4'($urandom_range(1, 15)));
	endtask

	task automatic run_frame_phase(input bit first);
		int pause_at;
		int n;
		calm = ($urandom_range(0, 4) == 0);
		cfg_val[ookpw_pkg::CFG_TE] = first ? 20'd2 : pick_te();
		cfg_val[ookpw_pkg::CFG_BITS] = first ? 20'd63 : pick_bits();
		cfg_val[ookpw_pkg::CFG_REPEAT] = first ? 20'd1 : pick_repeat();
		cfg_val[ookpw_pkg::CFG_GAP] = pick_gap_len();
		apply_cfg(first ? ALL_REGS : 4'($urandom_range(0, 15)));
		repeat ($urandom_range(0, 2)) send_item(ookpw_pkg::OP_TICK, $urandom);
		send_item(ookpw_pkg::OP_START, pick_word());
		pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 80) : -1;
		n = 0;
		while (sb.busy()) begin
			if (!extremes_done && sb.ticks > 4) begin
				hold_extremes();
				extremes_done = 1'b1;
			end else if (n == pause_at) begin
				if ($urandom_range(0, 1) == 1 && sb.ticks > 4) hold_extremes();
				else retune();
			end
			if ($urandom_range(0, 19) == 0) send_item(ookpw_pkg::OP_START, $urandom);
			else send_item(ookpw_pkg::OP_TICK, $urandom);
			n++;
		end
	endtask

	initial begin : out_stall_drv
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_item(in_data);
			if (out_valid && !out_stall) sb.check_level(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = ookpw_pkg::CFG_TE;
		cfg_data = '0;
		calm = 1'b0;
		extremes_done = 1'b0;
		counted = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle ticks, zero repeat, start while busy, minimal frame
		send_item(ookpw_pkg::OP_TICK, $urandom);
		send_item(ookpw_pkg::OP_TICK, $urandom);
		cfg_val[ookpw_pkg::CFG_REPEAT] = 20'd0;
		apply_cfg(4'b1 << ookpw_pkg::CFG_REPEAT);
		send_item(ookpw_pkg::OP_START, 32'hFFFF_FFFF);
		send_item(ookpw_pkg::OP_START, 32'h0000_0000);
		cfg_val[ookpw_pkg::CFG_TE] = 20'd0;
		cfg_val[ookpw_pkg::CFG_BITS] = 20'd0;
		cfg_val[ookpw_pkg::CFG_REPEAT] = 20'd1;
		cfg_val[ookpw_pkg::CFG_GAP] = 20'd0;
		apply_cfg(ALL_REGS);
		send_item(ookpw_pkg::OP_START, 32'hA5A5_5A5A);
		send_item(ookpw_pkg::OP_START, 32'hFFFF_FFFF);
		while (sb.busy()) send_item(ookpw_pkg::OP_TICK, $urandom);
		send_item(ookpw_pkg::OP_TICK, $urandom);

		counted = 0;
		run_frame_phase(1'b1);
		while (counted < RAND_ITEMS) run_frame_phase(1'b0);

		// repeated shortest frame
		calm = 1'b0;
		cfg_val[ookpw_pkg::CFG_TE] = 20'd0;
		cfg_val[ookpw_pkg::CFG_BITS] = 20'd0;
		cfg_val[ookpw_pkg::CFG_REPEAT] = 20'd12;
		cfg_val[ookpw_pkg::CFG_GAP] = 20'd0;
		apply_cfg(ALL_REGS);
		send_item(ookpw_pkg::OP_START, $urandom);
		while (sb.busy()) send_item(ookpw_pkg::OP_TICK, $urandom);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
